FILE: src/sfd_pkg.sv
// Shared types, codes and the CRC16-XMODEM byte update for the frame deframer.
// No dependencies; used by sfd_core and serial_frame_deframer_crc16.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    // Frame parser phases, in frame order
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_ID     = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC_HI = 3'd5,
        PH_CRC_LO = 3'd6
    } phase_t;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes
    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_LEN  = 2'd2;
    localparam logic [1:0] ST_INC  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_MAX_LEN    = 1'b1;

    // Reset values and fixed numbers of the frame format
    localparam logic [7:0]  START_BYTE_RST = 8'h55;
    localparam logic [15:0] MAX_LEN_RST    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_INIT       = 16'h0000;
    localparam logic [15:0] OVERHEAD_LEN   = 16'd6;
    localparam logic [15:0] CRC_LEN        = 16'd2;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    // One result item
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  frame_id;
        logic [1:0]  frame_status;
        logic [15:0] payload_length;
        logic [15:0] bytes_consumed;
    } sfd_result_t;

    // CRC16-XMODEM update by one byte, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/sfd_core.sv
// Frame parser state and per-byte step logic: phase, length, position, CRC, id, skip count.
// Depends on sfd_pkg for the phase type, codes, result struct and CRC update.
`timescale 1ns / 1ps
`default_nettype none

module sfd_core
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        chunk_last,
    input  wire logic [7:0]  start_byte,
    input  wire logic [15:0] max_frame_len,
    output logic             res_valid,
    output sfd_result_t      res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] skip_reg, skip_next;

    // Shared decode of the current byte
    logic        is_start;
    logic [15:0] pos_inc;
    logic [15:0] len_full;
    logic        len_bad;
    logic        at_crc_pos;
    logic [15:0] crc_upd;
    logic [15:0] plen_cur;
    logic        emit_status;

    // Status assembly
    logic        st_valid;
    logic [1:0]  st_code;
    logic [15:0] st_consumed;
    logic [15:0] st_plen;
    logic [7:0]  st_id;
    logic [16:0] total_sum;

    assign is_start   = (rx_byte == start_byte);
    assign pos_inc    = pos_reg + 16'd1;
    assign len_full   = {rx_byte, len_reg[7:0]};
    assign len_bad    = (len_full < OVERHEAD_LEN) || (len_full > max_frame_len);
    assign at_crc_pos = (pos_inc == (len_reg - CRC_LEN));
    assign crc_upd    = crc16_step((phase_reg == PH_HUNT) ? CRC_INIT : crc_reg, rx_byte);
    assign plen_cur   = len_reg - OVERHEAD_LEN;

    // Decide the result for this byte
    always_comb
    begin
        st_valid    = 1'b0;
        st_code     = ST_GOOD;
        st_consumed = pos_inc;
        st_plen     = '0;
        st_id       = id_reg;
        res_valid   = 1'b0;
        res         = '0;
        case (phase_reg)
            PH_HUNT:
            begin
                st_valid    = is_start && chunk_last;
                st_code     = ST_INC;
                st_consumed = 16'd1;
                st_id       = '0;
            end
            PH_LEN_LO:
            begin
                st_valid = chunk_last;
                st_code  = ST_INC;
            end
            PH_LEN_HI:
            begin
                if (len_bad)
                begin
                    st_valid = 1'b1;
                    st_code  = ST_LEN;
                end
                else
                begin
                    st_valid = chunk_last;
                    st_code  = ST_INC;
                    st_plen  = len_full - OVERHEAD_LEN;
                end
            end
            PH_ID:
            begin
                st_valid = chunk_last;
                st_code  = ST_INC;
                st_plen  = plen_cur;
                st_id    = rx_byte;
            end
            PH_DATA, PH_CRC_HI:
            begin
                st_valid = chunk_last;
                st_code  = ST_INC;
                st_plen  = plen_cur;
            end
            PH_CRC_LO:
            begin
                st_valid    = 1'b1;
                st_code     = (crc_upd == '0) ? ST_GOOD : ST_CRC;
                st_consumed = len_reg;
                st_plen     = plen_cur;
            end
            default:
            begin
                st_valid = 1'b0;
            end
        endcase

        // Saturate the skip plus frame byte count
        total_sum = {1'b0, skip_reg} + {1'b0, st_consumed};

        if (st_valid)
        begin
            res_valid          = 1'b1;
            res.item_kind      = KIND_STATUS;
            res.frame_id       = st_id;
            res.frame_status   = st_code;
            res.payload_length = st_plen;
            res.bytes_consumed = total_sum[16] ? COUNT_MAX : total_sum[15:0];
        end
        else if (phase_reg == PH_DATA)
        begin
            res_valid        = 1'b1;
            res.item_kind    = KIND_PAYLOAD;
            res.payload_byte = rx_byte;
            res.frame_id     = id_reg;
        end
    end

    assign emit_status = res_valid && (res.item_kind == KIND_STATUS);

    // Next parser state
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        id_next    = id_reg;
        skip_next  = skip_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (is_start)
                begin
                    crc_next   = crc_upd;
                    len_next   = '0;
                    id_next    = '0;
                    pos_next   = 16'd1;
                    phase_next = PH_LEN_LO;
                end
                else if (chunk_last)
                begin
                    skip_next = '0;
                end
                else if (skip_reg != COUNT_MAX)
                begin
                    skip_next = skip_reg + 16'd1;
                end
            end
            PH_LEN_LO:
            begin
                crc_next   = crc_upd;
                pos_next   = pos_inc;
                len_next   = {8'h00, rx_byte};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                crc_next   = crc_upd;
                pos_next   = pos_inc;
                len_next   = len_full;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                crc_next   = crc_upd;
                pos_next   = pos_inc;
                id_next    = rx_byte;
                phase_next = at_crc_pos ? PH_CRC_HI : PH_DATA;
            end
            PH_DATA:
            begin
                crc_next = crc_upd;
                pos_next = pos_inc;
                if (at_crc_pos)
                begin
                    phase_next = PH_CRC_HI;
                end
            end
            PH_CRC_HI:
            begin
                crc_next   = crc_upd;
                pos_next   = pos_inc;
                phase_next = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                crc_next = crc_upd;
                pos_next = pos_inc;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        // Drop back to hunting after any status
        if (emit_status)
        begin
            phase_next = PH_HUNT;
            skip_next  = '0;
        end
    end

    // Advance state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            id_reg    <= '0;
            skip_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            id_reg    <= id_next;
            skip_reg  <= skip_next;
        end
    end

`ifndef ASSERT_OFF
    a_status_rehunts: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && emit_status |=> (phase_reg == PH_HUNT) && (skip_reg == '0))
        else $error("parser did not return to hunting after a status item");

    a_payload_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res_valid && (res.item_kind == KIND_PAYLOAD) |-> (phase_reg == PH_DATA))
        else $error("payload item outside the data phase");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ID) || (phase_reg == PH_DATA) || (phase_reg == PH_CRC_HI)
        || (phase_reg == PH_CRC_LO) |-> (pos_reg < len_reg) && (len_reg >= OVERHEAD_LEN))
        else $error("byte position ran past the declared frame length");

    a_good_zero_residue: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && emit_status && (res.frame_status == ST_GOOD) |=> (crc_reg == '0))
        else $error("good status with nonzero CRC residue");
`endif

endmodule

`default_nettype wire

FILE: src/serial_frame_deframer_crc16.sv
// Path: an accepted request waits in the input register; its result, if any, is then loaded
// into the output register once that register has room.
// Throughput: one byte per cycle unless a stalled, full output register holds a result; the parser step
// between the input and output register (CRC byte update plus length compare) sets that figure.
// Reset: rst_n clears all control state and returns to hunting with start byte 0x55 and
// maximum frame length 65535; no clearing pass.
// Top level: config registers, input register, output register; uses sfd_pkg, sfd_core.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_deframer_crc16
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wr_data,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        chunk_last,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             item_kind,
    output logic [7:0]       payload_byte,
    output logic [7:0]       frame_id,
    output logic [1:0]       frame_status,
    output logic [15:0]      payload_length,
    output logic [15:0]      bytes_consumed
);

    logic [7:0]  start_byte_reg;
    logic [15:0] max_len_reg;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    logic        out_valid_reg, out_valid_next;
    sfd_result_t out_reg;

    logic        in_accept;
    logic        out_free;
    logic        step_en;
    logic        res_valid;
    sfd_result_t res;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            max_len_reg    <= MAX_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_START_BYTE: start_byte_reg <= cfg_wr_data[7:0];
                CFG_MAX_LEN:    max_len_reg    <= cfg_wr_data;
                default:        start_byte_reg <= start_byte_reg;
            endcase
        end
    end

    // Step the parser when its result, if any, has room
    assign out_free  = !out_valid_reg || !out_stall;
    assign step_en   = s1_valid_reg && (!res_valid || out_free);
    assign in_stall  = s1_valid_reg && !step_en;
    assign in_accept = in_valid && !in_stall;

    sfd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .rx_byte       (s1_byte_reg),
        .chunk_last    (s1_last_reg),
        .start_byte    (start_byte_reg),
        .max_frame_len (max_len_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Hold the accepted request until the parser takes it
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= rx_byte;
            s1_last_reg <= chunk_last;
        end
    end

    // Load the result register, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_en && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign item_kind      = out_reg.item_kind;
    assign payload_byte   = out_reg.payload_byte;
    assign frame_id       = out_reg.frame_id;
    assign frame_status   = out_reg.frame_status;
    assign payload_length = out_reg.payload_length;
    assign bytes_consumed = out_reg.bytes_consumed;

endmodule

`default_nettype wire
